>>> src/utf_pkg.sv
// ----------------------------------------------------------------------------
// utf_pkg
// Request codes, payload structs and the FIFO control structs shared by the
// UART transmit/receive FIFO pair.
// ----------------------------------------------------------------------------
package utf_pkg;

  localparam int unsigned FIFO_DEPTH = 256;
  localparam int unsigned LEVEL_W    = 9;
  localparam int unsigned BYTE_W     = 8;

  typedef enum logic [2:0] {
    REQ_HOST_WRITE = 3'd0,
    REQ_HOST_READ  = 3'd1,
    REQ_LINE_SEND  = 3'd2,
    REQ_LINE_RECV  = 3'd3,
    REQ_FLUSH      = 3'd4,
    REQ_OPEN       = 3'd5
  } req_e;

  typedef enum logic [1:0] {
    POP_NONE = 2'd0,
    POP_RECV = 2'd1,
    POP_SEND = 2'd2
  } pop_sel_e;

  typedef struct packed {
    logic [2:0]        req_type;
    logic [BYTE_W-1:0] data_in;
  } req_t;

  typedef struct packed {
    logic               status;
    logic [BYTE_W-1:0]  data_out;
    logic [LEVEL_W-1:0] recv_level;
    logic [LEVEL_W-1:0] send_level;
    logic [LEVEL_W-1:0] flushed_count;
    logic               tx_irq_enable;
    logic               rx_irq_enable;
    logic               tx_complete;
    logic               rx_full;
  } result_t;

  // Pointer commands from the controller to one FIFO
  typedef struct packed {
    logic push;
    logic pop;
    logic flush;
    logic clear;
  } fifo_cmd_t;

  // Occupancy status of one FIFO
  typedef struct packed {
    logic empty;
    logic full;
  } fifo_stat_t;

endpackage

>>> src/utf_ram.sv
// ----------------------------------------------------------------------------
// utf_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module utf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> src/utf_fifo_ptr.sv
// ----------------------------------------------------------------------------
// utf_fifo_ptr
// Free-running read/write pointer pair of one ring FIFO, with level and
// empty/full status.
// ----------------------------------------------------------------------------
module utf_fifo_ptr import utf_pkg::*; #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned IDX_W = $clog2(DEPTH),
  parameter int unsigned PTR_W = IDX_W + 1
) (
  input  logic             clk,
  input  logic             rst,
  input  fifo_cmd_t        cmd,
  output fifo_stat_t       stat,
  output logic [PTR_W-1:0] level,
  output logic [IDX_W-1:0] rd_idx,
  output logic [IDX_W-1:0] wr_idx
);

  logic [PTR_W-1:0] rd_ptr, rd_ptr_next;
  logic [PTR_W-1:0] wr_ptr, wr_ptr_next;

  // Occupancy from the pointer difference, wrapping modulo twice the depth
  assign level      = wr_ptr - rd_ptr;
  assign stat.empty = (level == '0);
  assign stat.full  = level[PTR_W-1];
  assign rd_idx     = rd_ptr[IDX_W-1:0];
  assign wr_idx     = wr_ptr[IDX_W-1:0];

  // Advance, flush or clear the pointers
  always_comb begin
    rd_ptr_next = rd_ptr;
    wr_ptr_next = wr_ptr;
    if (cmd.clear) begin
      rd_ptr_next = '0;
      wr_ptr_next = '0;
    end else if (cmd.flush) begin
      rd_ptr_next = wr_ptr;
    end else begin
      if (cmd.push) begin
        wr_ptr_next = wr_ptr + PTR_W'(1);
      end
      if (cmd.pop) begin
        rd_ptr_next = rd_ptr + PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
    end else begin
      rd_ptr <= rd_ptr_next;
      wr_ptr <= wr_ptr_next;
    end
  end

  // Never push into a full FIFO nor pop an empty one
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    cmd.push |-> !stat.full)
    else $error("push into full FIFO");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    cmd.pop |-> !stat.empty)
    else $error("pop from empty FIFO");
  a_level_bound: assert property (@(posedge clk) disable iff (rst)
    level <= PTR_W'(DEPTH))
    else $error("FIFO level beyond depth");

endmodule

>>> src/utf_ctrl.sv
// ----------------------------------------------------------------------------
// utf_ctrl
// Request decoder, flow-control flags and result register of the FIFO pair.
// ----------------------------------------------------------------------------
module utf_ctrl import utf_pkg::*; #(
  parameter int unsigned PTR_W = 9
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  req_t              req,
  input  fifo_stat_t        send_stat,
  input  fifo_stat_t        recv_stat,
  input  logic [PTR_W-1:0]  send_level,
  input  logic [PTR_W-1:0]  recv_level,
  input  logic [BYTE_W-1:0] send_q,
  input  logic [BYTE_W-1:0] recv_q,
  output fifo_cmd_t         send_cmd,
  output fifo_cmd_t         recv_cmd,
  output logic              done,
  output result_t           result
);

  logic complete_flag, complete_flag_next;
  logic full_flag, full_flag_next;
  logic tx_int_en, tx_int_en_next;
  logic rx_int_en, rx_int_en_next;

  logic               status, status_next;
  pop_sel_e           pop_sel, pop_sel_next;
  logic [LEVEL_W-1:0] flushed, flushed_next;

  // Decode the request into pointer commands and flag updates
  always_comb begin
    send_cmd           = '0;
    recv_cmd           = '0;
    complete_flag_next = complete_flag;
    full_flag_next     = full_flag;
    tx_int_en_next     = tx_int_en;
    rx_int_en_next     = rx_int_en;
    status_next        = 1'b0;
    pop_sel_next       = POP_NONE;
    flushed_next       = '0;
    if (start) begin
      case (req.req_type)
        REQ_HOST_WRITE: begin
          send_cmd.push = !send_stat.full;
          status_next   = send_stat.full;
          if (complete_flag) begin
            complete_flag_next = 1'b0;
            tx_int_en_next     = 1'b1;
          end
        end
        REQ_HOST_READ: begin
          recv_cmd.pop = !recv_stat.empty;
          status_next  = recv_stat.empty;
          if (!recv_stat.empty) begin
            pop_sel_next = POP_RECV;
          end
          if (full_flag) begin
            full_flag_next = 1'b0;
            rx_int_en_next = 1'b1;
          end
        end
        REQ_LINE_SEND: begin
          if (send_stat.empty) begin
            complete_flag_next = 1'b1;
            tx_int_en_next     = 1'b0;
            status_next        = 1'b1;
          end else begin
            send_cmd.pop = 1'b1;
            pop_sel_next = POP_SEND;
          end
        end
        REQ_LINE_RECV: begin
          if (recv_stat.full) begin
            full_flag_next = 1'b1;
            rx_int_en_next = 1'b0;
            status_next    = 1'b1;
          end else begin
            recv_cmd.push = 1'b1;
          end
        end
        REQ_FLUSH: begin
          send_cmd.flush     = 1'b1;
          recv_cmd.flush     = 1'b1;
          complete_flag_next = 1'b1;
          full_flag_next     = 1'b0;
          flushed_next       = LEVEL_W'(recv_level);
        end
        REQ_OPEN: begin
          send_cmd.clear     = 1'b1;
          recv_cmd.clear     = 1'b1;
          complete_flag_next = 1'b1;
          full_flag_next     = 1'b0;
          rx_int_en_next     = 1'b1;
        end
        default: begin
          status_next = 1'b1;
        end
      endcase
    end
  end

  // Hold the flags and the control part of the result
  always_ff @(posedge clk) begin
    if (rst) begin
      complete_flag <= 1'b1;
      full_flag     <= 1'b0;
      tx_int_en     <= 1'b0;
      rx_int_en     <= 1'b1;
      done          <= 1'b0;
      pop_sel       <= POP_NONE;
    end else begin
      complete_flag <= complete_flag_next;
      full_flag     <= full_flag_next;
      tx_int_en     <= tx_int_en_next;
      rx_int_en     <= rx_int_en_next;
      done          <= start;
      pop_sel       <= pop_sel_next;
    end
  end

  always_ff @(posedge clk) begin
    status  <= status_next;
    flushed <= flushed_next;
  end

  // Assemble the result from the registers; state already reflects the step
  always_comb begin
    result.status        = status;
    case (pop_sel)
      POP_RECV: result.data_out = recv_q;
      POP_SEND: result.data_out = send_q;
      default:  result.data_out = '0;
    endcase
    result.recv_level    = LEVEL_W'(recv_level);
    result.send_level    = LEVEL_W'(send_level);
    result.flushed_count = flushed;
    result.tx_irq_enable = tx_int_en;
    result.rx_irq_enable = rx_int_en;
    result.tx_complete   = complete_flag;
    result.rx_full       = full_flag;
  end

  a_one_result: assert property (@(posedge clk) disable iff (rst)
    start |=> done)
    else $error("request without result");
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    !start |=> !done)
    else $error("result without request");
  a_send_idle: assert property (@(posedge clk) disable iff (rst)
    (start && req.req_type == REQ_LINE_SEND && send_stat.empty)
      |=> (complete_flag && !tx_int_en && status))
    else $error("idle line send did not set complete");
  a_recv_overrun: assert property (@(posedge clk) disable iff (rst)
    (start && req.req_type == REQ_LINE_RECV && recv_stat.full)
      |=> (full_flag && !rx_int_en && status))
    else $error("receive overrun did not pause");

endmodule

>>> src/uart_tx_rx_fifo_flow_control.sv
// A request accepted at one edge has its result on the ports in the next
// cycle, marked by done; one request can be taken every cycle. The byte read
// comes from the registered read port of the byte RAMs.
// busy stays low, so start alone accepts a request; results cannot be stalled.
// Reset (synchronous) clears the pointers, sets tx complete and clears rx full;
// the byte stores are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
// uart_tx_rx_fifo_flow_control
// Transmit and receive byte ring FIFOs of a UART with flow-control flags,
// handling one host or line-side request per cycle.
// ----------------------------------------------------------------------------
module uart_tx_rx_fifo_flow_control import utf_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  output logic    busy,
  input  req_t    req,
  output logic    done,
  output result_t result
);

  localparam int unsigned IDX_W = $clog2(FIFO_DEPTH);
  localparam int unsigned PTR_W = IDX_W + 1;

  fifo_cmd_t        send_cmd, recv_cmd;
  fifo_stat_t       send_stat, recv_stat;
  logic [PTR_W-1:0] send_level, recv_level;
  logic [IDX_W-1:0] send_rd_idx, send_wr_idx, recv_rd_idx, recv_wr_idx;
  logic [BYTE_W-1:0] send_q, recv_q;

  assign busy = 1'b0;

  // Request decode, flags and result
  utf_ctrl #(
    .PTR_W (PTR_W)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .req        (req),
    .send_stat  (send_stat),
    .recv_stat  (recv_stat),
    .send_level (send_level),
    .recv_level (recv_level),
    .send_q     (send_q),
    .recv_q     (recv_q),
    .send_cmd   (send_cmd),
    .recv_cmd   (recv_cmd),
    .done       (done),
    .result     (result)
  );

  // Transmit FIFO
  utf_fifo_ptr #(
    .DEPTH (FIFO_DEPTH)
  ) u_send_ptr (
    .clk    (clk),
    .rst    (rst),
    .cmd    (send_cmd),
    .stat   (send_stat),
    .level  (send_level),
    .rd_idx (send_rd_idx),
    .wr_idx (send_wr_idx)
  );

  utf_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (FIFO_DEPTH)
  ) u_send_ram (
    .clk   (clk),
    .we    (send_cmd.push),
    .waddr (send_wr_idx),
    .wdata (req.data_in),
    .re    (send_cmd.pop),
    .raddr (send_rd_idx),
    .rdata (send_q)
  );

  // Receive FIFO
  utf_fifo_ptr #(
    .DEPTH (FIFO_DEPTH)
  ) u_recv_ptr (
    .clk    (clk),
    .rst    (rst),
    .cmd    (recv_cmd),
    .stat   (recv_stat),
    .level  (recv_level),
    .rd_idx (recv_rd_idx),
    .wr_idx (recv_wr_idx)
  );

  utf_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (FIFO_DEPTH)
  ) u_recv_ram (
    .clk   (clk),
    .we    (recv_cmd.push),
    .waddr (recv_wr_idx),
    .wdata (req.data_in),
    .re    (recv_cmd.pop),
    .raddr (recv_rd_idx),
    .rdata (recv_q)
  );

endmodule
